/* src/sierra_dither_palette_blend_defines.svh */
// assertion helpers used by the checker
`ifndef SIERRA_DITHER_PALETTE_BLEND_DEFINES_SVH
`define SIERRA_DITHER_PALETTE_BLEND_DEFINES_SVH

// antecedent in one cycle, consequent in the next, quiet during reset
`define SDPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must follow a cycle spent in reset
`define SDPB_ASSERT_RESET(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

/* src/sdpb_pkg.sv */
`default_nettype none
package sdpb_pkg;

  // fixed widths of the item fields and the error cells
  localparam int CELL_W = 20;
  localparam int COL_W  = 12;
  localparam int SPAN_W = 15;
  localparam int DIST_W = 18;

  typedef enum logic [1:0] {
    MODE_SPAN  = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_PAL   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_PAINT   = 2'd0,
    CFG_DITHER  = 2'd1,
    CFG_ENTRIES = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN,
    ST_RD_ISSUE,
    ST_RD_TAKE,
    ST_PAL_RD,
    ST_PAL_SQ0,
    ST_PAL_SQ1,
    ST_PAL_SQ2,
    ST_PAL_CMP,
    ST_PAL_FETCH,
    ST_PAL_GET,
    ST_SPR_RD,
    ST_SPR_WR,
    ST_BL_MUL,
    ST_BL_ACC,
    ST_OUT
  } sdpb_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  pos_x;
    logic [15:0] pos_y;
    logic [10:0] span_count;
    logic [7:0]  coverage;
    logic [7:0]  dst_red;
    logic [7:0]  dst_green;
    logic [7:0]  dst_blue;
    logic [7:0]  dst_alpha;
    logic [7:0]  palette_index;
    logic [23:0] entry_color;
  } in_item_t;

  typedef struct packed {
    logic [9:0] out_x;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

  // residue mod 3 from base-4 digit sum
  function automatic logic [1:0] mod3_u16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] s2;
    s = '0;
    for (int i = 0; i < 8; i++) s = s + 5'(v[2*i +: 2]);
    s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (s2 >= 3'd6) s2 = s2 - 3'd6;
    else if (s2 >= 3'd3) s2 = s2 - 3'd3;
    return s2[1:0];
  endfunction

  // (a + b) mod 3 for a, b below 3
  function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = 3'(a) + 3'(b);
    if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

  // ((v + 1) * 257) >> 16
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    logic [24:0] s;
    t = 17'(v) + 17'd1;
    s = {t, 8'd0} + 25'(t);
    return s[23:16];
  endfunction

  // diffusion taps: target row offset
  function automatic logic [1:0] spread_row(input logic [3:0] t);
    logic [1:0] r;
    unique case (t)
      4'd0, 4'd1:                      r = 2'd0;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6:    r = 2'd1;
      default:                         r = 2'd2;
    endcase
    return r;
  endfunction

  // diffusion taps: column offset plus two
  function automatic logic [2:0] spread_dxp(input logic [3:0] t);
    logic [2:0] d;
    unique case (t)
      4'd0:    d = 3'd3;
      4'd1:    d = 3'd4;
      4'd2:    d = 3'd0;
      4'd3:    d = 3'd1;
      4'd4:    d = 3'd2;
      4'd5:    d = 3'd3;
      4'd6:    d = 3'd4;
      4'd7:    d = 3'd1;
      4'd8:    d = 3'd2;
      default: d = 3'd3;
    endcase
    return d;
  endfunction

  // diffusion taps: weight over 32
  function automatic logic [2:0] spread_w(input logic [3:0] t);
    logic [2:0] w;
    unique case (t)
      4'd0:    w = 3'd5;
      4'd1:    w = 3'd3;
      4'd2:    w = 3'd2;
      4'd3:    w = 3'd4;
      4'd4:    w = 3'd5;
      4'd5:    w = 3'd4;
      4'd6:    w = 3'd2;
      4'd7:    w = 3'd2;
      4'd8:    w = 3'd3;
      default: w = 3'd2;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* src/sdpb_if.sv */
`default_nettype none
// input item channel
interface sdpb_in_if;
  import sdpb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface sdpb_out_if;
  import sdpb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/sierra_dither_palette_blend.sv */
// channel   dir   handshake        payload
// in_if     in    valid / ready    mode, span, coverage, destination, palette entry
// out_if    out   valid / ready    out_x and blended rgba
// cfg_*     in    cfg_we           cfg_index, cfg_wdata (32 bits)
//
// after reset a clearing pass writes all 3*(LINE_WIDTH+4)*4 error cells, one a cycle
// (12336 cells at LINE_WIDTH 1024); no item is taken meanwhile
// span start with dithering sweeps three error rows, one error cell per cycle
// pixel with dithering: n palette entries searched one after another, sequenced through
// the shared multiplier and the single error memory port; without dithering it goes straight to blending
// palette writes and other items return straight to idle; a waiting result stalls only the
// next pixel at its final step
`default_nettype none
module sierra_dither_palette_blend #(
  parameter int LINE_WIDTH          = 1024,
  parameter int PALETTE_DEPTH       = 256,
  parameter int ERROR_FRACTION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  sdpb_in_if.sink           in_if,
  sdpb_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import sdpb_pkg::*;

  localparam int F         = ERROR_FRACTION_BITS;
  localparam int CELLS     = LINE_WIDTH + 4;
  localparam int ROWLEN    = CELLS * 4;
  localparam int MEM_DEPTH = 3 * ROWLEN;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CIW       = $clog2(ROWLEN + 1);
  localparam int WW        = (CIW > SPAN_W ? CIW : SPAN_W) + 1;
  localparam int PAW       = $clog2(PALETTE_DEPTH);
  localparam int PCW       = $clog2(PALETTE_DEPTH + 1);
  localparam int HW        = F + 8;
  localparam int EW        = F + 10;
  localparam int VW        = (HW > CELL_W ? HW : CELL_W) + 2;
  localparam int PW        = EW + 10;
  localparam int SW        = PW + 1;
  localparam int TOP       = 255 * (2 ** F);
  localparam int HALF      = 2 ** (F - 1);
  localparam int CELL_MAX  = 2 ** (CELL_W - 1) - 1;
  localparam int CELL_MIN  = -(2 ** (CELL_W - 1));

  // start address of an error row
  function automatic logic [AW-1:0] row_base(input logic [1:0] row);
    logic [AW-1:0] b;
    unique case (row)
      2'd1:    b = AW'(ROWLEN);
      2'd2:    b = AW'(2 * ROWLEN);
      default: b = '0;
    endcase
    return b;
  endfunction

  sdpb_state_t state_r, state_nxt;

  // control and architectural state
  logic [AW-1:0]      clr_addr_r;
  logic [31:0]        paint_r;
  logic               dither_r;
  logic [8:0]         entries_r;
  logic [9:0]         span_x_r;
  logic [10:0]        cursor_r;
  logic signed [17:0] last_row_r;
  logic [CIW-1:0]     prev_lo_r, prev_hi_r;
  logic [1:0]         base_r;
  logic               out_valid_r;

  // working registers
  logic [CIW-1:0]     lo_r, hi_r, pl_r, pr_r, cur_c_r;
  logic [1:0]         roll_r, row_j_r;
  logic [COL_W-1:0]   col_r;
  logic [7:0]         cov_r;
  logic [7:0]         dst_r [4];
  logic [7:0]         c_r [4];
  logic [HW-1:0]      held_r [4];
  logic [1:0]         kc_r;
  logic [3:0]         tc_r;
  logic [2:0]         bc_r;
  logic [PCW-1:0]     pi_r;
  logic [PAW-1:0]     best_r;
  logic [DIST_W-1:0]  bestd_r, acc_r;
  logic [7:0]         a_r;
  logic [7:0]         res_r [4];
  logic signed [PW-1:0] prod_r;
  out_item_t          out_data_r;

  // memories
  logic signed [CELL_W-1:0] err_mem [MEM_DEPTH];
  logic signed [CELL_W-1:0] err_rd_r;
  logic [23:0]              pal_mem [PALETTE_DEPTH];
  logic [23:0]              pal_rd_r;

  logic                     in_acc;
  logic [AW-1:0]            err_addr;
  logic                     err_we;
  logic signed [CELL_W-1:0] err_wd;
  logic [PAW-1:0]           pal_raddr;
  logic                     pal_we;
  logic [PCW-1:0]           n_c;
  logic [WW-1:0]            ctr_w, tap_w;
  logic                     ctr_ok, tap_ok;
  logic                     span_go, span_full, out_load;
  logic signed [CELL_W-1:0] e_s;
  logic signed [VW-1:0]     v_s;
  logic [HW-1:0]            held_c;
  logic [HW:0]              rnd_c;
  logic signed [EW-1:0]     err_s;
  logic signed [EW-1:0]     mul_a;
  logic signed [9:0]        mul_b;
  logic signed [8:0]        df_s;
  logic [7:0]               pal_byte;
  logic [1:0]               dk;
  logic [7:0]               opa, opb, ia, dv;
  logic signed [PW-1:0]     share_s;
  logic signed [SW-1:0]     sum_s;
  logic [DIST_W-1:0]        d_c;
  logic [WW-1:0]            lo_w, hi_w, hsum_w;
  logic [CIW-1:0]           lo_c, hi_c;
  logic signed [18:0]       roll_s;
  logic [1:0]               roll_c;

  assign in_acc        = in_if.valid && in_if.ready;
  assign in_if.ready   = (state_r == ST_IDLE);
  assign out_if.valid  = out_valid_r;
  assign out_if.data   = out_data_r;
  assign out_load      = !out_valid_r || out_if.ready;

  // searched palette size
  assign n_c = (entries_r > 9'(PALETTE_DEPTH)) ? PCW'(PALETTE_DEPTH) : PCW'(entries_r);

  // error columns of the current pixel and tap
  assign ctr_w  = WW'(col_r) + WW'(2);
  assign tap_w  = WW'(col_r) + WW'(spread_dxp(tc_r));
  assign ctr_ok = ctr_w < WW'(CELLS);
  assign tap_ok = tap_w < WW'(CELLS);

  // span clearing sweep
  assign span_go   = cur_c_r < hi_r;
  assign span_full = (3'(row_j_r) + 3'(roll_r)) >= 3'd3;

  // span bounds and row advance from the incoming item
  always_comb begin
    lo_w   = WW'({in_if.data.pos_x, 2'b00});
    hsum_w = WW'(in_if.data.pos_x) + WW'(in_if.data.span_count) + WW'(4);
    hi_w   = {hsum_w[WW-3:0], 2'b00};
    lo_c   = (lo_w > WW'(ROWLEN)) ? CIW'(ROWLEN) : CIW'(lo_w);
    hi_c   = (hi_w > WW'(ROWLEN)) ? CIW'(ROWLEN) : CIW'(hi_w);
    roll_s = $signed({3'b000, in_if.data.pos_y}) - 19'(last_row_r);
    if (roll_s < 0 || roll_s > 19'sd3) roll_c = 2'd3;
    else roll_c = roll_s[1:0];
  end

  // add stored error, clamp and round one channel
  always_comb begin
    e_s    = ctr_ok ? err_rd_r : '0;
    v_s    = $signed(VW'({c_r[kc_r], {F{1'b0}}})) + VW'(e_s);
    if (v_s < 0) held_c = '0;
    else if (v_s > VW'(TOP)) held_c = HW'(TOP);
    else held_c = HW'(v_s);
    rnd_c  = (HW+1)'(held_c) + (HW+1)'(HALF);
  end

  // quantization error of the current channel
  assign err_s = $signed(EW'(held_r[kc_r])) - $signed(EW'({c_r[kc_r], {F{1'b0}}}));

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_PAL_SQ1: dk = 2'd1;
      ST_PAL_SQ2: dk = 2'd2;
      default:    dk = 2'd0;
    endcase
    pal_byte = pal_rd_r[8*dk +: 8];
    df_s     = $signed({1'b0, c_r[dk]}) - $signed({1'b0, pal_byte});
    ia       = 8'd255 - a_r;
    case (bc_r)
      3'd0:    begin opa = cov_r;               opb = c_r[3]; end
      3'd1:    begin opa = c_r[0];              opb = a_r; end
      3'd2:    begin opa = c_r[1];              opb = a_r; end
      3'd3:    begin opa = c_r[2];              opb = a_r; end
      3'd4:    begin opa = ia;                  opb = dst_r[0]; end
      3'd5:    begin opa = ia;                  opb = dst_r[1]; end
      3'd6:    begin opa = ia;                  opb = dst_r[2]; end
      default: begin opa = ia;                  opb = dst_r[3]; end
    endcase
    unique case (state_r)
      ST_PAL_SQ0, ST_PAL_SQ1, ST_PAL_SQ2: begin
        mul_a = EW'(df_s);
        mul_b = 10'(df_s);
      end
      ST_SPR_RD: begin
        mul_a = err_s;
        mul_b = $signed(10'(spread_w(tc_r)));
      end
      ST_BL_MUL: begin
        mul_a = $signed(EW'(opa));
        mul_b = $signed(10'(opb));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // spread share added to a stored cell (saturated at the write), blend division by 255 and distance sum
  always_comb begin
    share_s = prod_r >>> 5;
    sum_s   = SW'(err_rd_r) + SW'(share_s);
    dv      = div255(prod_r[15:0]);
    d_c     = acc_r + prod_r[DIST_W-1:0];
  end

  // error memory port
  always_comb begin
    err_we = 1'b0;
    err_wd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        err_addr = clr_addr_r;
        err_we   = 1'b1;
      end
      ST_SPAN: begin
        err_addr = row_base(add_mod3(base_r, row_j_r)) + AW'(cur_c_r);
        err_we   = span_go && (span_full || cur_c_r < pl_r || cur_c_r >= pr_r);
      end
      ST_SPR_RD, ST_SPR_WR: begin
        err_addr = row_base(add_mod3(base_r, spread_row(tc_r))) + AW'({tap_w, kc_r});
        err_we   = (state_r == ST_SPR_WR) && tap_ok;
        if (sum_s > SW'(CELL_MAX)) err_wd = CELL_W'(CELL_MAX);
        else if (sum_s < SW'(CELL_MIN)) err_wd = CELL_W'(CELL_MIN);
        else err_wd = CELL_W'(sum_s);
      end
      default: err_addr = row_base(base_r) + AW'({ctr_w, kc_r});
    endcase
  end

  always_ff @(posedge clk) begin
    if (err_we) err_mem[err_addr] <= err_wd;
    err_rd_r <= err_mem[err_addr];
  end

  // palette memory port
  assign pal_we    = in_acc && (in_if.data.mode == MODE_PAL) &&
                     (9'(in_if.data.palette_index) < 9'(PALETTE_DEPTH));
  assign pal_raddr = (state_r == ST_PAL_FETCH) ? best_r : pi_r[PAW-1:0];

  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[PAW'(in_if.data.palette_index)] <= in_if.data.entry_color;
    pal_rd_r <= pal_mem[pal_raddr];
  end

  // shared multiplier output register
  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:
        if (clr_addr_r == AW'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:
        if (in_acc) begin
          unique case (in_if.data.mode)
            MODE_SPAN:  if (dither_r) state_nxt = ST_SPAN;
            MODE_PIXEL: state_nxt = dither_r ? ST_RD_ISSUE : ST_BL_MUL;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      ST_SPAN:
        if (!span_go && row_j_r == 2'd2) state_nxt = ST_IDLE;
      ST_RD_ISSUE: state_nxt = ST_RD_TAKE;
      ST_RD_TAKE:
        if (kc_r == 2'd3) state_nxt = (n_c == '0) ? ST_PAL_FETCH : ST_PAL_RD;
        else state_nxt = ST_RD_ISSUE;
      ST_PAL_RD:  state_nxt = ST_PAL_SQ0;
      ST_PAL_SQ0: state_nxt = ST_PAL_SQ1;
      ST_PAL_SQ1: state_nxt = ST_PAL_SQ2;
      ST_PAL_SQ2: state_nxt = ST_PAL_CMP;
      ST_PAL_CMP:
        state_nxt = (pi_r + PCW'(1) == n_c) ? ST_PAL_FETCH : ST_PAL_RD;
      ST_PAL_FETCH: state_nxt = ST_PAL_GET;
      ST_PAL_GET:   state_nxt = ST_SPR_RD;
      ST_SPR_RD:    state_nxt = ST_SPR_WR;
      ST_SPR_WR:
        state_nxt = (tc_r == 4'd9 && kc_r == 2'd3) ? ST_BL_MUL : ST_SPR_RD;
      ST_BL_MUL: state_nxt = ST_BL_ACC;
      ST_BL_ACC: state_nxt = (bc_r == 3'd7) ? ST_OUT : ST_BL_MUL;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // configuration, span state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      paint_r     <= '0;
      dither_r    <= 1'b0;
      entries_r   <= '0;
      span_x_r    <= '0;
      cursor_r    <= '0;
      last_row_r  <= -18'sd3;
      prev_lo_r   <= '0;
      prev_hi_r   <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAINT:   paint_r   <= cfg_wdata;
          CFG_DITHER:  dither_r  <= cfg_wdata[0];
          CFG_ENTRIES: entries_r <= cfg_wdata[8:0];
          default:     ;
        endcase
      end
      if (in_acc && in_if.data.mode == MODE_SPAN) begin
        span_x_r <= in_if.data.pos_x;
        cursor_r <= '0;
        if (dither_r) begin
          last_row_r <= $signed({2'b00, in_if.data.pos_y});
          prev_lo_r  <= lo_c;
          prev_hi_r  <= hi_c;
          base_r     <= mod3_u16(in_if.data.pos_y);
        end
      end
      if (in_acc && in_if.data.mode == MODE_PIXEL) cursor_r <= cursor_r + 11'd1;
      if (state_r == ST_OUT && out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE:
        if (in_acc) begin
          // span clearing bounds
          lo_r    <= lo_c;
          hi_r    <= hi_c;
          pl_r    <= prev_lo_r;
          pr_r    <= prev_hi_r;
          roll_r  <= roll_c;
          cur_c_r <= lo_c;
          row_j_r <= '0;
          // pixel setup
          col_r    <= COL_W'(span_x_r) + COL_W'(cursor_r);
          cov_r    <= in_if.data.coverage;
          dst_r[0] <= in_if.data.dst_red;
          dst_r[1] <= in_if.data.dst_green;
          dst_r[2] <= in_if.data.dst_blue;
          dst_r[3] <= in_if.data.dst_alpha;
          for (int k = 0; k < 4; k++) c_r[k] <= paint_r[8*k +: 8];
          kc_r    <= '0;
          tc_r    <= '0;
          bc_r    <= '0;
          pi_r    <= '0;
          best_r  <= '0;
          bestd_r <= '1;
        end
      ST_SPAN:
        if (span_go) cur_c_r <= cur_c_r + CIW'(1);
        else begin
          cur_c_r <= lo_r;
          row_j_r <= row_j_r + 2'd1;
        end
      ST_RD_TAKE: begin
        held_r[kc_r] <= held_c;
        c_r[kc_r]    <= rnd_c[F +: 8];
        kc_r         <= kc_r + 2'd1;
      end
      ST_PAL_SQ1: acc_r <= prod_r[DIST_W-1:0];
      ST_PAL_SQ2: acc_r <= acc_r + prod_r[DIST_W-1:0];
      ST_PAL_CMP: begin
        if (d_c < bestd_r) begin
          bestd_r <= d_c;
          best_r  <= pi_r[PAW-1:0];
        end
        pi_r <= pi_r + PCW'(1);
      end
      ST_PAL_GET:
        for (int k = 0; k < 3; k++) c_r[k] <= pal_rd_r[8*k +: 8];
      ST_SPR_WR: begin
        kc_r <= kc_r + 2'd1;
        if (kc_r == 2'd3) tc_r <= tc_r + 4'd1;
      end
      ST_BL_ACC: begin
        case (bc_r)
          3'd0: begin
            a_r      <= dv;
            res_r[3] <= dv;
          end
          3'd1:    res_r[0] <= dv;
          3'd2:    res_r[1] <= dv;
          3'd3:    res_r[2] <= dv;
          3'd4:    res_r[0] <= res_r[0] + dv;
          3'd5:    res_r[1] <= res_r[1] + dv;
          3'd6:    res_r[2] <= res_r[2] + dv;
          default: res_r[3] <= res_r[3] + dv;
        endcase
        bc_r <= bc_r + 3'd1;
      end
      ST_OUT:
        if (out_load) begin
          out_data_r.out_x     <= col_r[9:0];
          out_data_r.out_red   <= res_r[0];
          out_data_r.out_green <= res_r[1];
          out_data_r.out_blue  <= res_r[2];
          out_data_r.out_alpha <= res_r[3];
        end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/sdpb_checker.sv */
`default_nettype none
`include "sierra_dither_palette_blend_defines.svh"
module sdpb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_mode,
  input logic                out_valid,
  input logic                out_ready,
  input sdpb_pkg::out_item_t out_data
);
  import sdpb_pkg::*;

  // clearing pass keeps the input closed after reset
  `SDPB_ASSERT_RESET(a_closed_after_reset, clk, rst_n, !in_ready, "input open after reset")

  // a pixel item keeps the block busy in the cycle after it is taken
  `SDPB_ASSERT_NEXT(a_pixel_busy, clk, rst_n, in_valid && in_ready && in_mode == MODE_PIXEL, !in_ready, "ready right after pixel item")

  // no result appears in the cycle right after an item is taken
  `SDPB_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result without latency")

  // a stalled result stays offered
  `SDPB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped under stall")

  // a stalled result keeps its payload
  `SDPB_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data), "result changed under stall")

endmodule

bind sierra_dither_palette_blend sdpb_checker u_sdpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_mode   (in_if.data.mode),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
`default_nettype wire
